### src/cte_pkg.sv
// Shared constants, command codes and control structs for the clique table.
`default_nettype none
package cte_pkg;

    localparam int CAPACITY    = 1024;
    localparam int NODE_BITS   = 8;
    localparam int CLIQUE_SIZE = 7;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int LEVEL_W     = $clog2(CAPACITY + 1);
    localparam int COUNT_W     = 11;
    localparam int ENTRY_W     = CLIQUE_SIZE * NODE_BITS + 1;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_COUNT = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic load_out;
    } cte_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic last_addr;
    } cte_stat_t;

endpackage
`default_nettype wire

### src/clique_table_edge_count.sv
// Top level of the clique table: add cliques, count cliques holding two vertices.
//
//   channel  signals               direction  payload
//   in       in_valid / in_ready   input      cmd, color, node0..node6
//   out      out_valid / out_ready output     match_count, status
//
// An add writes the table at the transfer and goes straight to the finish state for its result.
// A count on a nonempty table walks it with one memory read per stored clique through the
// single read port, then a drain state for the registered read data and the result load.
// Reset empties the table (fill level zero); memory contents are not cleared.
// A stalled result holds in the output register; the next item is taken while it waits,
// and its own result waits until the output register is free.
`default_nettype none
module clique_table_edge_count (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic                          color,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node0,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node1,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node2,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node3,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node4,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node5,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node6,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cte_pkg::COUNT_W-1:0]        match_count,
    output logic                               status
);

    cte_pkg::cte_cmd_t  ctl;
    cte_pkg::cte_stat_t stat;

    cte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl),
        .stat      (stat)
    );

    cte_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cmd         (cmd),
        .color       (color),
        .node0       (node0),
        .node1       (node1),
        .node2       (node2),
        .node3       (node3),
        .node4       (node4),
        .node5       (node5),
        .node6       (node6),
        .match_count (match_count),
        .status      (status)
    );

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in progress");

    a_full_has_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == cte_pkg::STATUS_FULL) |-> (match_count == '0))
        else $error("dropped add reports a nonzero count");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (match_count <= cte_pkg::COUNT_W'(cte_pkg::CAPACITY)))
        else $error("match count above table capacity");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.full && ctl.accept) |=> stat.full)
        else $error("fill level moved past a full table");

endmodule
`default_nettype wire

### src/cte_dp.sv
// Datapath: clique memory, fill level, walk address, match counter, result registers.
`default_nettype none
module cte_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cte_pkg::cte_cmd_t             ctl,
    output cte_pkg::cte_stat_t                 stat,
    input  wire logic                          cmd,
    input  wire logic                          color,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node0,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node1,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node2,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node3,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node4,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node5,
    input  wire logic [cte_pkg::NODE_BITS-1:0] node6,
    output logic [cte_pkg::COUNT_W-1:0]        match_count,
    output logic                               status
);

    logic [cte_pkg::ENTRY_W-1:0]   mem [cte_pkg::CAPACITY];
    logic [cte_pkg::ENTRY_W-1:0]   rd_data_reg;
    logic [cte_pkg::ENTRY_W-1:0]   wr_entry;
    logic                          rd_valid_reg;
    logic [cte_pkg::LEVEL_W-1:0]   fill_level_reg;
    logic [cte_pkg::LEVEL_W-1:0]   addr_reg;
    logic [cte_pkg::LEVEL_W-1:0]   addr_inc;
    logic [cte_pkg::COUNT_W-1:0]   count_reg;
    logic                          status_pend_reg;
    logic [cte_pkg::NODE_BITS-1:0] qa_reg;
    logic [cte_pkg::NODE_BITS-1:0] qb_reg;
    logic [cte_pkg::COUNT_W-1:0]   match_count_reg;
    logic                          status_reg;
    logic                          hit_a;
    logic                          hit_b;
    logic                          do_write;

    assign wr_entry = {color, node6, node5, node4, node3, node2, node1, node0};
    assign addr_inc = addr_reg + cte_pkg::LEVEL_W'(1);

    assign stat.empty     = (fill_level_reg == '0);
    assign stat.full      = (fill_level_reg == cte_pkg::LEVEL_W'(cte_pkg::CAPACITY));
    assign stat.last_addr = (addr_inc == fill_level_reg);

    assign do_write = ctl.accept && (cmd == cte_pkg::CMD_ADD) && !stat.full;

    always_comb
    begin
        hit_a = 1'b0;
        hit_b = 1'b0;
        for (int r = 0; r < cte_pkg::CLIQUE_SIZE; r++)
        begin
            if (rd_data_reg[r*cte_pkg::NODE_BITS +: cte_pkg::NODE_BITS] == qa_reg)
            begin
                hit_a = 1'b1;
            end
            if (rd_data_reg[r*cte_pkg::NODE_BITS +: cte_pkg::NODE_BITS] == qb_reg)
            begin
                hit_b = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[fill_level_reg[cte_pkg::ADDR_W-1:0]] <= wr_entry;
        end
        if (ctl.rd_issue)
        begin
            rd_data_reg <= mem[addr_reg[cte_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_level_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= ctl.rd_issue;
            if (do_write)
            begin
                fill_level_reg <= fill_level_reg + cte_pkg::LEVEL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            qa_reg          <= node0;
            qb_reg          <= node1;
            addr_reg        <= '0;
            count_reg       <= '0;
            status_pend_reg <= (cmd == cte_pkg::CMD_ADD && stat.full) ?
                               cte_pkg::STATUS_FULL : cte_pkg::STATUS_OK;
        end
        else
        begin
            if (ctl.rd_issue)
            begin
                addr_reg <= addr_inc;
            end
            if (rd_valid_reg && hit_a && hit_b)
            begin
                count_reg <= count_reg + cte_pkg::COUNT_W'(1);
            end
        end
        if (ctl.load_out)
        begin
            match_count_reg <= count_reg;
            status_reg      <= status_pend_reg;
        end
    end

    assign match_count = match_count_reg;
    assign status      = status_reg;

endmodule
`default_nettype wire

### src/cte_ctrl.sv
// Controller: command sequencing, table walk and output register handshake.
`default_nettype none
module cte_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cte_pkg::cte_cmd_t       ctl,
    input  wire cte_pkg::cte_stat_t stat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        ctl.accept   = 1'b0;
        ctl.rd_issue = 1'b0;
        ctl.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    if (cmd == cte_pkg::CMD_COUNT && !stat.empty)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_WALK:
            begin
                ctl.rd_issue = 1'b1;
                if (stat.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### tb/clique_table_edge_count_tb.sv
// Self-checking testbench for the clique table: adds, counts, full table, random traffic.
`timescale 1ns / 1ps
module tb;

    localparam int RUN_LIMIT = 10_000_000;
    localparam int RANDOM_ITEMS = 450;
    localparam logic [cte_pkg::NODE_BITS-1:0] HUB_VERTEX = 8'd251;

    typedef logic [cte_pkg::CLIQUE_SIZE-1:0][cte_pkg::NODE_BITS-1:0] clique_t;

    typedef struct packed {
        logic    cmd;
        logic    color;
        clique_t nodes;
    } table_cmd_t;

    typedef struct packed {
        logic [cte_pkg::COUNT_W-1:0] count;
        logic                        status;
    } table_reply_t;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic                          cmd       = cte_pkg::CMD_ADD;
    logic                          color     = 1'b0;
    logic [cte_pkg::NODE_BITS-1:0] node0     = '0;
    logic [cte_pkg::NODE_BITS-1:0] node1     = '0;
    logic [cte_pkg::NODE_BITS-1:0] node2     = '0;
    logic [cte_pkg::NODE_BITS-1:0] node3     = '0;
    logic [cte_pkg::NODE_BITS-1:0] node4     = '0;
    logic [cte_pkg::NODE_BITS-1:0] node5     = '0;
    logic [cte_pkg::NODE_BITS-1:0] node6     = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [cte_pkg::COUNT_W-1:0]   match_count;
    logic                          status;

    clique_t      stored_cliques [cte_pkg::CAPACITY];
    int           table_fill  = 0;
    table_reply_t awaited_replies [$];
    int           errors      = 0;
    int           cycle_count = 0;
    bit           idling      = 1'b1;

    clique_table_edge_count uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .color       (color),
        .node0       (node0),
        .node1       (node1),
        .node2       (node2),
        .node3       (node3),
        .node4       (node4),
        .node5       (node5),
        .node6       (node6),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .match_count (match_count),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic table_reply_t apply_command(table_cmd_t it);
        table_reply_t r;
        logic         has_a;
        logic         has_b;
        r.count  = '0;
        r.status = cte_pkg::STATUS_OK;
        if (it.cmd == cte_pkg::CMD_ADD)
        begin
            if (table_fill >= cte_pkg::CAPACITY)
                r.status = cte_pkg::STATUS_FULL;
            else
            begin
                stored_cliques[table_fill] = it.nodes;
                table_fill++;
            end
        end
        else
        begin
            for (int p = 0; p < table_fill; p++)
            begin
                has_a = 1'b0;
                has_b = 1'b0;
                for (int k = 0; k < cte_pkg::CLIQUE_SIZE; k++)
                begin
                    if (stored_cliques[p][k] == it.nodes[0])
                        has_a = 1'b1;
                    if (stored_cliques[p][k] == it.nodes[1])
                        has_b = 1'b1;
                end
                if (has_a && has_b)
                    r.count = r.count + 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_item(input table_cmd_t it);
        int gap;
        if (idling && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= it.cmd;
        color    <= it.color;
        node0    <= it.nodes[0];
        node1    <= it.nodes[1];
        node2    <= it.nodes[2];
        node3    <= it.nodes[3];
        node4    <= it.nodes[4];
        node5    <= it.nodes[5];
        node6    <= it.nodes[6];
        do
            @(posedge clk);
        while (!in_ready);
        awaited_replies.push_back(apply_command(it));
    endtask

    task automatic send_add(input logic col, input clique_t verts);
        table_cmd_t it;
        it.cmd   = cte_pkg::CMD_ADD;
        it.color = col;
        it.nodes = verts;
        send_item(it);
    endtask

    task automatic send_count(input logic [cte_pkg::NODE_BITS-1:0] a,
                              input logic [cte_pkg::NODE_BITS-1:0] b);
        table_cmd_t it;
        it.cmd   = cte_pkg::CMD_COUNT;
        it.color = 1'($urandom_range(0, 1));
        for (int k = 0; k < cte_pkg::CLIQUE_SIZE; k++)
            it.nodes[k] = cte_pkg::NODE_BITS'($urandom_range(0, 255));
        it.nodes[0] = a;
        it.nodes[1] = b;
        send_item(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_count(8'h00, 8'h00);
        send_count(8'hFF, 8'hFF);
        send_add(1'b0, {7{8'h00}});
        send_add(1'b1, {7{8'hFF}});
        send_add(1'b1, {7{8'd5}});
        send_add(1'b0, {8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'hFF, 8'h00});
        send_add(1'b1, {8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1});
        send_add(1'b0, {8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA});
        send_add(1'b1, {8'd70, 8'd60, 8'd50, 8'd40, 8'd30, 8'd20, 8'd10});
        send_count(8'h00, 8'h00);
        send_count(8'h00, 8'hFF);
        send_count(8'hFF, 8'h00);
        send_count(8'hFF, 8'hFF);
        send_count(8'd5, 8'd5);
        send_count(8'd1, 8'd7);
        send_count(8'd7, 8'd1);
        send_count(8'd200, 8'd201);
        send_count(8'hAA, 8'h55);
        send_count(8'd10, 8'd70);
        send_count(8'd70, 8'd10);
        send_count(8'h00, 8'd5);
        send_count(8'd5, 8'hFF);
    endtask

    task automatic test_random();
        table_cmd_t it;
        int         row;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 60 == 0)
                idling = ($urandom_range(0, 2) != 0);
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            it.cmd   = ($urandom_range(0, 99) < 45) ? cte_pkg::CMD_ADD : cte_pkg::CMD_COUNT;
            it.color = 1'($urandom_range(0, 1));
            for (int k = 0; k < cte_pkg::CLIQUE_SIZE; k++)
                it.nodes[k] = cte_pkg::NODE_BITS'(($urandom_range(0, 3) != 0) ?
                                                  $urandom_range(0, 15) :
                                                  $urandom_range(0, 255));
            if (it.cmd == cte_pkg::CMD_COUNT && table_fill != 0 && $urandom_range(0, 3) != 0)
            begin
                row = int'($urandom_range(0, table_fill - 1));
                it.nodes[0] = stored_cliques[row][$urandom_range(0, cte_pkg::CLIQUE_SIZE - 1)];
                it.nodes[1] = stored_cliques[row][$urandom_range(0, cte_pkg::CLIQUE_SIZE - 1)];
            end
            send_item(it);
        end
        idling = 1'b1;
    endtask

    task automatic test_full();
        table_cmd_t it;
        it.cmd = cte_pkg::CMD_ADD;
        while (table_fill < cte_pkg::CAPACITY)
        begin
            it.color = 1'($urandom_range(0, 1));
            for (int k = 0; k < cte_pkg::CLIQUE_SIZE; k++)
                it.nodes[k] = cte_pkg::NODE_BITS'($urandom_range(0, 255));
            it.nodes[$urandom_range(0, cte_pkg::CLIQUE_SIZE - 1)] = HUB_VERTEX;
            send_item(it);
            if (table_fill % 256 == 0)
                send_count(HUB_VERTEX, it.nodes[$urandom_range(0, cte_pkg::CLIQUE_SIZE - 1)]);
        end
        idling = 1'b0;
        send_count(HUB_VERTEX, HUB_VERTEX);
        for (int j = 0; j < 4; j++)
        begin
            it.color = j[0];
            for (int k = 0; k < cte_pkg::CLIQUE_SIZE; k++)
                it.nodes[k] = cte_pkg::NODE_BITS'($urandom_range(0, 255));
            send_item(it);
        end
        send_count(HUB_VERTEX, HUB_VERTEX);
        send_count(8'h00, 8'hFF);
        send_count(8'd5, 8'd5);
    endtask

    initial
    begin : sink_stall
        int hold;
        @(posedge clk);
        forever
        begin
            if (idling && rst_n && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                hold = $urandom_range(1, 13);
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : reply_check
        table_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual count %0d status %0d",
                         $time, match_count, status);
                errors++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (match_count !== want.count)
                begin
                    $display("%0t: match_count mismatch: expected %0d, actual %0d",
                             $time, want.count, match_count);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_full();
        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### filelist.f
src/cte_pkg.sv
src/cte_dp.sv
src/cte_ctrl.sv
src/clique_table_edge_count.sv
tb/clique_table_edge_count_tb.sv
